// File: hdl/csv_field_tokenizer_assert.svh
// assertion macros for the csv field tokenizer
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CSVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CSVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/csvt_pkg.sv
// package with types, constants and helpers of the csv field tokenizer
`timescale 1ns / 1ps

package csvt_pkg;

  localparam logic [7:0] SEMICOLON_BYTE = 8'h3B;
  localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
  localparam logic [7:0] QUOTE_BYTE     = 8'h22;

  localparam int unsigned SPACE_HOLD_DEPTH_DEF = 32;
  localparam int unsigned HOLD_CNT_W           = 6;
  localparam int unsigned QUEUE_DEPTH          = 4;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_FIELD_ROW = 2'd2,
    KIND_ROW_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DATA,
    OP_MARK
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SPACE,
    BK_BYTE
  } back_state_e;

  typedef struct packed {
    op_e                   op;
    kind_e                 kind;
    logic [7:0]            data;
    logic [HOLD_CNT_W-1:0] idx;
    logic                  ovf;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b inside {[8'd9:8'd13], 8'd32, 8'h85, 8'hA0});
  endfunction

endpackage

// File: hdl/csvt_if.sv
// valid/ready channel interfaces for input words and result words
`timescale 1ns / 1ps

interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] text_byte;

  modport source (output valid, output action, output text_byte, input ready);
  modport sink   (input valid, input action, input text_byte, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       ws_overflow;
  logic       last;

  modport source (output valid, output kind, output out_byte, output ws_overflow,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input ws_overflow,
                  input last, output ready);
endinterface

// File: hdl/csvt_front.sv
// front part: accepts input words, tracks parse state, issues commands
`timescale 1ns / 1ps

module csvt_front #(
  parameter int unsigned SpaceHoldDepth = csvt_pkg::SPACE_HOLD_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  csvt_in_if.sink           in_i,
  input  logic [7:0]        sep_i,
  input  csvt_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output csvt_pkg::cmd_t    cmd_o
);
  import csvt_pkg::*;

  localparam logic [HOLD_CNT_W-1:0] DepthCnt = HOLD_CNT_W'(SpaceHoldDepth);

  logic inq_q, inq_d, qp_q, qp_d, fo_q, fo_d, ro_q, ro_d, cs_q, cs_d, ovf_q, ovf_d;
  logic [HOLD_CNT_W-1:0] cnt_q, cnt_d;

  logic       accept;
  logic       take_content;
  logic       normal;
  logic       inq_v;
  logic [7:0] b;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.text_byte;

  always_comb begin
    inq_d = inq_q;
    qp_d  = qp_q;
    fo_d  = fo_q;
    ro_d  = ro_q;
    cs_d  = cs_q;
    ovf_d = ovf_q;
    cnt_d = cnt_q;
    push_o = 1'b0;
    cmd_o.op   = OP_MARK;
    cmd_o.kind = KIND_DATA;
    cmd_o.data = b;
    cmd_o.idx  = cnt_q;
    cmd_o.ovf  = ovf_q;
    take_content = 1'b0;
    normal = 1'b1;
    inq_v  = inq_q;
    if (accept) begin
      if (in_i.action) begin
        if (fo_q) begin
          push_o     = 1'b1;
          cmd_o.kind = KIND_FIELD_ROW;
        end else if (ro_q) begin
          push_o     = 1'b1;
          cmd_o.kind = KIND_ROW_END;
        end
        inq_d = 1'b0;
        qp_d  = 1'b0;
        fo_d  = 1'b0;
        ro_d  = 1'b0;
        cs_d  = 1'b0;
        ovf_d = 1'b0;
        cnt_d = '0;
      end else begin
        fo_d = 1'b1;
        ro_d = 1'b1;
        if (qp_q) begin
          qp_d = 1'b0;
          if (b == QUOTE_BYTE) begin
            take_content = 1'b1;
            normal = 1'b0;
          end else begin
            inq_v = 1'b0;
          end
        end
        inq_d = inq_v;
        if (normal) begin
          if (b == QUOTE_BYTE) begin
            if (inq_v) begin
              qp_d = 1'b1;
            end else begin
              inq_d = 1'b1;
            end
          end else if (b == sep_i && !inq_v) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_FIELD_END;
            fo_d  = 1'b0;
            cs_d  = 1'b0;
            cnt_d = '0;
            ovf_d = 1'b0;
          end else if (b == NEWLINE_BYTE && !inq_v) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_FIELD_ROW;
            fo_d  = 1'b0;
            ro_d  = 1'b0;
            cs_d  = 1'b0;
            cnt_d = '0;
            ovf_d = 1'b0;
          end else begin
            take_content = 1'b1;
          end
        end
        if (take_content) begin
          if (is_ws(b)) begin
            if (cs_q) begin
              if (cnt_q < DepthCnt) begin
                push_o   = 1'b1;
                cmd_o.op = OP_HOLD;
                cnt_d    = cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
          end else begin
            push_o   = 1'b1;
            cmd_o.op = OP_DATA;
            cnt_d    = '0;
            cs_d     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_q <= 1'b0;
      qp_q  <= 1'b0;
      fo_q  <= 1'b0;
      ro_q  <= 1'b0;
      cs_q  <= 1'b0;
      ovf_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      inq_q <= inq_d;
      qp_q  <= qp_d;
      fo_q  <= fo_d;
      ro_q  <= ro_d;
      cs_q  <= cs_d;
      ovf_q <= ovf_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/csvt_fifo.sv
// short command queue between the front and back parts
`timescale 1ns / 1ps

module csvt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csvt_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output csvt_pkg::cmd_t    cmd_o,
  output csvt_pkg::q_stat_t stat_o
);
  import csvt_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: hdl/csvt_back.sv
// back part: holds trailing whitespace, drains it and drives result words
`timescale 1ns / 1ps

module csvt_back #(
  parameter int unsigned SpaceHoldDepth = csvt_pkg::SPACE_HOLD_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csvt_pkg::cmd_t    cmd_i,
  input  csvt_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  csvt_out_if.source        out_o
);
  import csvt_pkg::*;

  localparam int unsigned IdxW = (SpaceHoldDepth > 1) ? $clog2(SpaceHoldDepth) : 1;

  back_state_e state_q, state_d;

  logic [7:0]            hold_mem [SpaceHoldDepth];
  logic [7:0]            rd_data_q;
  logic [IdxW-1:0]       rd_addr;
  logic [HOLD_CNT_W-1:0] idx_q, idx_d, cnt_q;
  logic [7:0]            byte_q;
  kind_e                 kind_q;
  logic                  ovf_q;

  logic       slot_free;
  logic       mem_we;
  logic       emit;
  kind_e      emit_kind;
  logic [7:0] emit_byte;
  logic       emit_last;

  logic       out_valid_q;
  logic [1:0] out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_ovf_q;
  logic       out_last_q;

  assign slot_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          case (cmd_i.op)
            OP_DATA: state_d = (cmd_i.idx != '0) ? BK_SPACE : BK_BYTE;
            OP_MARK: state_d = BK_BYTE;
            default: state_d = BK_IDLE;
          endcase
        end
      end
      BK_SPACE: begin
        if (slot_free && (idx_q + 1'b1 == cnt_q)) begin
          state_d = BK_BYTE;
        end
      end
      BK_BYTE: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    emit      = 1'b0;
    emit_kind = KIND_DATA;
    emit_byte = rd_data_q;
    emit_last = 1'b0;
    idx_d     = idx_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          mem_we = (cmd_i.op == OP_HOLD);
          idx_d  = '0;
        end
      end
      BK_SPACE: begin
        if (slot_free) begin
          emit  = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      BK_BYTE: begin
        emit      = slot_free;
        emit_kind = kind_q;
        emit_byte = (kind_q == KIND_DATA) ? byte_q : 8'h00;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign rd_addr = idx_d[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hold_mem[cmd_i.idx[IdxW-1:0]] <= cmd_i.data;
    end
    rd_data_q <= hold_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cnt_q  <= cmd_i.idx;
      byte_q <= cmd_i.data;
      kind_q <= (cmd_i.op == OP_DATA) ? KIND_DATA : cmd_i.kind;
      ovf_q  <= cmd_i.ovf;
    end
    if (emit) begin
      out_kind_q <= emit_kind;
      out_byte_q <= emit_byte;
      out_ovf_q  <= ovf_q;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.ws_overflow = out_ovf_q;
  assign out_o.last        = out_last_q;

endmodule

// File: hdl/csv_field_tokenizer.sv
// top level of the csv field tokenizer: separator register, front, queue, back
//
// input words arrive on in_i: action 0 carries one text byte, action 1 ends
// the text, closes any open field or row and clears the parse state.
// result words leave on out_o: data bytes, field ends and row ends, with
// last set on the final result caused by an input word.
// cfg_we_i writes cfg_wdata_i into the field separator, semicolon at reset.
// the front takes one input word per cycle while the four-entry command
// queue has room; with the back idle a data result passes through the
// command queue, the back's byte register and the output register.
// the back writes a held space into the hold buffer while idle; a data byte
// or mark leaves in the byte state, after the space state flushes any held spaces.
// a stalled receiver holds the output register; the back then stops, the
// queue fills and in_i.ready drops once it is full.
// reset clears all parse state, the queue and the output valid flag; the
// hold buffer needs no clearing since only written entries are ever used.
`timescale 1ns / 1ps

module csv_field_tokenizer #(
  parameter int unsigned SpaceHoldDepth = csvt_pkg::SPACE_HOLD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csvt_in_if.sink    in_i,
  csvt_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import csvt_pkg::*;

  `include "csv_field_tokenizer_assert.svh"

  logic [7:0] sep_q;
  logic       push;
  logic       pop;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  q_stat_t    q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEMICOLON_BYTE;
    end else if (cfg_we_i) begin
      sep_q <= cfg_wdata_i;
    end
  end

  csvt_front #(.SpaceHoldDepth(SpaceHoldDepth)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .sep_i    (sep_q),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  csvt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  csvt_back #(.SpaceHoldDepth(SpaceHoldDepth)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (head_cmd),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  `CSVT_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "push into full queue")
  `CSVT_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
  `CSVT_ASSERT_NOW(a_full_blocks, q_stat.full, !in_i.ready, "ready while queue full")
  `CSVT_ASSERT_NOW(a_nonlast_data, out_o.valid && !out_o.last,
                   out_o.kind == KIND_DATA, "non-last result is not a data byte")

endmodule

// File: verif/csvt_tb_pkg.sv
// shared input word codes for the csv field tokenizer testbench
`timescale 1ns / 1ps

package csvt_tb_pkg;

  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_END  = 1'b1;

endpackage

// File: verif/csv_field_tokenizer_checker.sv
// checker that predicts csv tokenizer result words and compares them on the output channel
`timescale 1ns / 1ps

module csv_field_tokenizer_checker #(
  parameter int unsigned HoldDepth = csvt_pkg::SPACE_HOLD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csvt_in_if         mon_in,
  csvt_out_if        mon_out,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         result_count_o
);
  import csvt_pkg::*;
  import csvt_tb_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_val;
    logic       ovf;
    logic       last;
  } token_t;

  token_t     expected_tokens[$];
  token_t     word_tokens[$];
  token_t     exp_tok;

  logic [7:0] separator;
  logic       in_quotes;
  logic       quote_pend;
  logic       field_open;
  logic       row_open;
  logic       started;
  logic [7:0] hold_buf [HoldDepth];
  int         hold_cnt;
  logic       ovf_seen;
  int         fails;
  int         results;

  function automatic logic is_blank(input logic [7:0] b);
    return (b >= 8'd9 && b <= 8'd13) || b == 8'd32 || b == 8'h85 || b == 8'hA0;
  endfunction

  task automatic emit(input kind_e k, input logic [7:0] b);
    token_t t;
    t.kind     = k;
    t.byte_val = (k == KIND_DATA) ? b : 8'd0;
    t.ovf      = ovf_seen;
    t.last     = 1'b0;
    word_tokens = {word_tokens, t};
  endtask

  task automatic take_content(input logic [7:0] b);
    if (is_blank(b)) begin
      if (!started) return;
      if (hold_cnt < HoldDepth) begin
        hold_buf[hold_cnt] = b;
        hold_cnt++;
      end else begin
        ovf_seen = 1'b1;
      end
      return;
    end
    for (int i = 0; i < hold_cnt; i++) emit(KIND_DATA, hold_buf[i]);
    hold_cnt = 0;
    started  = 1'b1;
    emit(KIND_DATA, b);
  endtask

  task automatic end_field();
    field_open = 1'b0;
    started    = 1'b0;
    hold_cnt   = 0;
    ovf_seen   = 1'b0;
  endtask

  task automatic clear_parse();
    in_quotes  = 1'b0;
    quote_pend = 1'b0;
    row_open   = 1'b0;
    end_field();
  endtask

  task automatic predict_word(input logic act, input logic [7:0] b);
    logic done;
    done = 1'b0;
    word_tokens.delete();
    if (act == ACT_END) begin
      if (field_open) emit(KIND_FIELD_ROW, 8'd0);
      else if (row_open) emit(KIND_ROW_END, 8'd0);
      clear_parse();
    end else begin
      field_open = 1'b1;
      row_open   = 1'b1;
      if (quote_pend) begin
        quote_pend = 1'b0;
        if (b == QUOTE_BYTE) begin
          take_content(b);
          done = 1'b1;
        end else begin
          in_quotes = 1'b0;
        end
      end
      if (!done) begin
        if (b == QUOTE_BYTE) begin
          if (in_quotes) quote_pend = 1'b1;
          else in_quotes = 1'b1;
        end else if (b == separator && !in_quotes) begin
          emit(KIND_FIELD_END, 8'd0);
          end_field();
        end else if (b == NEWLINE_BYTE && !in_quotes) begin
          emit(KIND_FIELD_ROW, 8'd0);
          end_field();
          row_open = 1'b0;
        end else begin
          take_content(b);
        end
      end
    end
    if (word_tokens.size() > 0) word_tokens[word_tokens.size()-1].last = 1'b1;
    expected_tokens = {expected_tokens, word_tokens};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      separator = SEMICOLON_BYTE;
      expected_tokens.delete();
      fails   = 0;
      results = 0;
    end else begin
      if (mon_out.valid && mon_out.ready) begin
        results++;
        if (expected_tokens.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word kind %0d byte %h ovf %b last %b", $time,
                   mon_out.kind, mon_out.out_byte, mon_out.ws_overflow, mon_out.last);
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (mon_out.kind !== exp_tok.kind || mon_out.out_byte !== exp_tok.byte_val ||
              mon_out.ws_overflow !== exp_tok.ovf || mon_out.last !== exp_tok.last) begin
            fails++;
            $display("%0t: expected kind %0d byte %h ovf %b last %b, got %0d %h %b %b",
                     $time, exp_tok.kind, exp_tok.byte_val, exp_tok.ovf, exp_tok.last,
                     mon_out.kind, mon_out.out_byte, mon_out.ws_overflow, mon_out.last);
          end
        end
      end
      if (mon_in.valid && mon_in.ready) predict_word(mon_in.action, mon_in.text_byte);
      if (cfg_we_i) separator = cfg_wdata_i;
    end
    fail_count_o   <= fails;
    pending_o      <= expected_tokens.size();
    result_count_o <= results;
  end

endmodule

// File: verif/csv_field_tokenizer_test.sv
// testbench top for the csv field tokenizer: stimulus, idling phases and verdict
`timescale 1ns / 1ps

module csv_field_tokenizer_test;
  import csvt_pkg::*;
  import csvt_tb_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int NUM_SEPS     = 8;
  localparam int PHASE_WORDS  = 52;
  localparam int DRAIN_CYCLES = 64;

  localparam logic [7:0] SEP_LIST [NUM_SEPS] = '{
    8'h3B, 8'h2C, 8'h00, 8'hFF, 8'h22, 8'h0A, 8'h09, 8'h3B
  };

  localparam logic [8:0] DIRECTED [25] = '{
    {ACT_TEXT, 8'h61}, {ACT_TEXT, 8'h00}, {ACT_TEXT, 8'hFF}, {ACT_TEXT, 8'h20},
    {ACT_TEXT, 8'h85}, {ACT_TEXT, 8'h62}, {ACT_TEXT, 8'hA0}, {ACT_TEXT, 8'h3B},
    {ACT_TEXT, 8'h20}, {ACT_TEXT, 8'h22}, {ACT_TEXT, 8'h3B}, {ACT_TEXT, 8'h0A},
    {ACT_TEXT, 8'h22}, {ACT_TEXT, 8'h22}, {ACT_TEXT, 8'h22}, {ACT_TEXT, 8'h78},
    {ACT_TEXT, 8'h0A}, {ACT_TEXT, 8'h63}, {ACT_TEXT, 8'h3B}, {ACT_END,  8'hA5},
    {ACT_END,  8'h5A}, {ACT_TEXT, 8'h22}, {ACT_TEXT, 8'h71}, {ACT_TEXT, 8'h22},
    {ACT_END,  8'hFF}
  };

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  int         fail_count;
  int         pending;
  int         result_count;
  int         cycle_cnt  = 0;
  int         words_sent = 0;
  int         tx_pct = 0;
  int         rx_pct = 0;
  logic [7:0] cur_sep = SEMICOLON_BYTE;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();

  csv_field_tokenizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  csv_field_tokenizer_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mon_in         (in_ch),
    .mon_out        (out_ch),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_pct);
  end

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] blank_pick();
    case ($urandom_range(0, 7))
      0:       return 8'h09;
      1:       return 8'h0B;
      2:       return 8'h0C;
      3:       return 8'h0D;
      4:       return 8'h85;
      5:       return 8'hA0;
      default: return 8'h20;
    endcase
  endfunction

  task automatic send_word(input logic act, input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.text_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_blank_run();
    int n;
    n = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 40) : $urandom_range(1, 4);
    send_word(ACT_TEXT, letter());
    repeat (n) begin
      send_word(ACT_TEXT, blank_pick());
    end
  endtask

  task automatic send_quoted();
    int r;
    send_word(ACT_TEXT, QUOTE_BYTE);
    repeat ($urandom_range(0, 6)) begin
      r = $urandom_range(0, 9);
      if (r < 6) send_word(ACT_TEXT, letter());
      else if (r < 7) begin
        send_word(ACT_TEXT, QUOTE_BYTE);
        send_word(ACT_TEXT, QUOTE_BYTE);
      end else if (r < 8) send_word(ACT_TEXT, cur_sep);
      else if (r < 9) send_word(ACT_TEXT, NEWLINE_BYTE);
      else send_word(ACT_TEXT, blank_pick());
    end
    send_word(ACT_TEXT, QUOTE_BYTE);
  endtask

  task automatic send_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) repeat ($urandom_range(1, 6)) send_word(ACT_TEXT, letter());
    else if (r < 42) send_blank_run();
    else if (r < 54) send_word(ACT_TEXT, cur_sep);
    else if (r < 62) send_word(ACT_TEXT, NEWLINE_BYTE);
    else if (r < 74) send_quoted();
    else if (r < 90) send_word(ACT_TEXT, 8'($urandom));
    else if (r < 93) send_word(ACT_END, 8'($urandom));
    else send_word(ACT_TEXT, QUOTE_BYTE);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int goal;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_TEXT;
    in_ch.text_byte <= 8'h00;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_word(DIRECTED[i][8], DIRECTED[i][7:0]);
    goal = 0;
    for (int p = 0; p < NUM_SEPS; p++) begin
      wait_drained();
      if (p > 0) begin
        cur_sep     = SEP_LIST[p];
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= SEP_LIST[p];
        @(posedge clk_i);
        cfg_we_i    <= 1'b0;
      end
      case ((p + 1) % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 56; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 56; end
        default: begin tx_pct = 26; rx_pct = 26; end
      endcase
      goal += PHASE_WORDS;
      while (words_sent - 25 < goal) send_token();
    end
    wait_drained();

    $display("run covered %0d input words over %0d separator settings and four idling modes",
             words_sent, NUM_SEPS);
    $display("%0d result words compared, %0d mismatches", result_count, fail_count);
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
